[rtl/gradient_noise_2d_unit_assert.svh]
// ----------------------------------------------------------------------------
// gradient_noise_2d_unit_assert.svh
// Assertion macros for the gradient noise unit.
// ----------------------------------------------------------------------------
`ifndef GRADIENT_NOISE_2D_UNIT_ASSERT_SVH
`define GRADIENT_NOISE_2D_UNIT_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define GN2D_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define GN2D_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define GN2D_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define GN2D_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[rtl/gn2d_pkg.sv]
// ----------------------------------------------------------------------------
// gn2d_pkg
// Shared constants and types of the gradient noise unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gn2d_pkg;

    localparam int TABLE_SIZE_DEF      = 1024;
    localparam int COORD_FRAC_BITS_DEF = 16;

    localparam int HASH_BITS = 12;   // enough for the largest table
    localparam int IDX_BITS  = 13;   // holds a write index and the table size

    localparam logic [31:0] HASH_MUL_X = 32'd1836311903;
    localparam logic [31:0] HASH_MUL_Y = 32'd2971215073;
    localparam logic [32:0] HASH_ADD   = 33'd4807526976;

    localparam logic signed [15:0] RANGE_LO_RST = -16'sd4096;
    localparam logic signed [15:0] RANGE_HI_RST = 16'sd4096;

    localparam logic REG_RANGE_LO = 1'b0;
    localparam logic REG_RANGE_HI = 1'b1;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_EVAL  = 1'b1;

    typedef enum logic [1:0] {
        GRAD_POS_X = 2'd0,
        GRAD_NEG_X = 2'd1,
        GRAD_POS_Y = 2'd2,
        GRAD_NEG_Y = 2'd3
    } grad_code_t;

    localparam logic [16:0] ONE_Q16 = 17'd65536;

endpackage

`default_nettype wire

[rtl/gradient_noise_2d_unit.sv]
// ----------------------------------------------------------------------------
// gradient_noise_2d_unit
// 2D gradient noise: table load or evaluation at a Q15.16 point, Q4.12 out.
// ----------------------------------------------------------------------------
//  port group  dir  contents
//  s_*         in   word: table write (tuser 0) or noise evaluation (tuser 1)
//  m_*         out  word: one noise value per evaluation
//  cfg_*       in   register write: range low (0), range high (1)
//
//  One word enters per cycle while s_tready is high; its result reaches m_*
//  through eight pipeline stages: input, hash/table read, corner dots,
//  fade, two lerps, remap, ridge/saturate, then the output register. A table
//  write takes effect at the table read stage, so later words see it. While the
//  output word is held, the pipe keeps moving until the next result lands in
//  the skid register; then the whole pipe freezes until the output drains.
//  Reset clears valid bits and sets config registers to their reset values;
//  the table is not cleared.
`default_nettype none

module gradient_noise_2d_unit #(
    parameter int TABLE_SIZE      = gn2d_pkg::TABLE_SIZE_DEF,
    parameter int COORD_FRAC_BITS = gn2d_pkg::COORD_FRAC_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [9:0] table_index, [11:10] table_code, [43:12] point_x,
    // [75:44] point_y, [76] ridge, [79:77] zero
    input  wire logic [79:0] s_tdata,
    // [0] kind
    input  wire logic        s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [16:0] noise_value, [23:17] zero
    output logic [23:0]      m_tdata,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data
);
    import gn2d_pkg::*;

    localparam int AW = $clog2(TABLE_SIZE);
    localparam logic [63:0] FMASK = (64'd1 << COORD_FRAC_BITS) - 64'd1;

    function automatic logic signed [17:0] dot(input logic [1:0] code,
                                              input logic signed [17:0] dx,
                                              input logic signed [17:0] dy);
        logic signed [17:0] r;
        begin
            case (grad_code_t'(code))
                GRAD_POS_X: r = dx;
                GRAD_NEG_X: r = -dx;
                GRAD_POS_Y: r = dy;
                default:    r = -dy;
            endcase
            return r;
        end
    endfunction

    function automatic logic [AW-1:0] hash_idx(input logic [HASH_BITS-1:0] cx,
                                               input logic [HASH_BITS-1:0] cy);
        logic [HASH_BITS-1:0] h;
        begin
            h = HASH_BITS'(cx * HASH_MUL_X[HASH_BITS-1:0])
              ^ HASH_BITS'(cy * HASH_MUL_Y[HASH_BITS-1:0] + HASH_ADD[HASH_BITS-1:0]);
            return h[AW-1:0] & AW'(TABLE_SIZE - 1);
        end
    endfunction

    logic signed [15:0] range_lo_reg, range_hi_reg;

    logic en;
    logic skid_v_reg, out_v_reg;
    logic [16:0] skid_d_reg, out_d_reg;

    // stage 0: input
    logic        v0_reg, kind0_reg, ridge0_reg;
    logic [9:0]  tidx0_reg;
    logic [1:0]  tcode0_reg;
    logic [31:0] px0_reg, py0_reg;

    // stage 1..7
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic r1_reg, r2_reg, r3_reg, r4_reg, r5_reg, r6_reg;
    logic [15:0] fx1_reg, fy1_reg;
    logic signed [17:0] tl2_reg, tr2_reg, bl2_reg, br2_reg;
    logic signed [17:0] tl3_reg, tr3_reg, bl3_reg, br3_reg;
    logic signed [18:0] top4_reg, bot4_reg;
    logic [16:0] sy4_reg;
    logic signed [18:0] n5_reg;
    logic signed [20:0] v6_val_reg;
    logic [16:0] fin_reg;

    // stage 0 -> 1 logic
    logic [63:0] fxw, fyw;
    logic [15:0] fx, fy;
    logic [31:0] cx, cy;
    logic [HASH_BITS-1:0] cx0, cx1, cy0, cy1;
    logic [AW-1:0] a_tl, a_tr, a_bl, a_br;
    logic [IDX_BITS-1:0] widx;
    logic we;
    logic [1:0] c_tl, c_tr, c_bl, c_br;
    logic [16:0] sx, sy;

    always_comb
    begin
        fxw  = ((64'(px0_reg) & FMASK) << 8) >> (COORD_FRAC_BITS - 8);
        fyw  = ((64'(py0_reg) & FMASK) << 8) >> (COORD_FRAC_BITS - 8);
        fx   = fxw[15:0];
        fy   = fyw[15:0];
        cx   = 32'($signed(px0_reg) >>> COORD_FRAC_BITS);
        cy   = 32'($signed(py0_reg) >>> COORD_FRAC_BITS);
        cx0  = cx[HASH_BITS-1:0];
        cy0  = cy[HASH_BITS-1:0];
        cx1  = cx0 + HASH_BITS'(1);
        cy1  = cy0 + HASH_BITS'(1);
        a_tl = hash_idx(cx0, cy0);
        a_tr = hash_idx(cx1, cy0);
        a_bl = hash_idx(cx0, cy1);
        a_br = hash_idx(cx1, cy1);
        widx = IDX_BITS'(tidx0_reg);
        we   = en && v0_reg && (kind0_reg == KIND_WRITE)
               && (widx < IDX_BITS'(TABLE_SIZE));
    end

    gn2d_grad_ram #(.DEPTH(TABLE_SIZE), .AW(AW)) u_ram_tl (
        .clk(clk), .we(we), .waddr(widx[AW-1:0]), .wdata(tcode0_reg),
        .en(en), .raddr(a_tl), .rdata(c_tl));
    gn2d_grad_ram #(.DEPTH(TABLE_SIZE), .AW(AW)) u_ram_tr (
        .clk(clk), .we(we), .waddr(widx[AW-1:0]), .wdata(tcode0_reg),
        .en(en), .raddr(a_tr), .rdata(c_tr));
    gn2d_grad_ram #(.DEPTH(TABLE_SIZE), .AW(AW)) u_ram_bl (
        .clk(clk), .we(we), .waddr(widx[AW-1:0]), .wdata(tcode0_reg),
        .en(en), .raddr(a_bl), .rdata(c_bl));
    gn2d_grad_ram #(.DEPTH(TABLE_SIZE), .AW(AW)) u_ram_br (
        .clk(clk), .we(we), .waddr(widx[AW-1:0]), .wdata(tcode0_reg),
        .en(en), .raddr(a_br), .rdata(c_br));

    // fade output lands aligned with stage 3
    gn2d_fade u_fade_x (.clk(clk), .en(en), .t(fx), .s(sx));
    gn2d_fade u_fade_y (.clk(clk), .en(en), .t(fy), .s(sy));

    // arithmetic between stages
    logic signed [17:0] dx0, dx1, dy0, dy1;
    logic signed [18:0] d_top, d_bot;
    logic signed [36:0] p_top, p_bot;
    logic signed [19:0] d_n;
    logic signed [37:0] p_n;
    logic signed [19:0] n_off;
    logic signed [16:0] rng;
    logic signed [37:0] p_v;
    logic signed [20:0] v_next;
    logic signed [22:0] rd, rabs, rv;
    logic [16:0] fin_next;

    always_comb
    begin
        dx0   = $signed({2'b00, fx1_reg});
        dy0   = $signed({2'b00, fy1_reg});
        dx1   = dx0 - 18'sd65536;
        dy1   = dy0 - 18'sd65536;

        d_top = 19'(tr3_reg) - 19'(tl3_reg);
        d_bot = 19'(br3_reg) - 19'(bl3_reg);
        p_top = 37'(d_top) * $signed({20'd0, sx});
        p_bot = 37'(d_bot) * $signed({20'd0, sx});

        d_n   = 20'(bot4_reg) - 20'(top4_reg);
        p_n   = 38'(d_n) * $signed({21'd0, sy4_reg});

        n_off = 20'(n5_reg) + 20'sd65536;
        rng   = 17'(range_hi_reg) - 17'(range_lo_reg);
        p_v   = 38'(n_off) * 38'(rng);
        v_next = 21'(range_lo_reg) + 21'(p_v >>> 17);

        rd   = 23'sd2048 - 23'(v6_val_reg);
        rabs = (rd < 0) ? -rd : rd;
        rv   = r6_reg ? ((23'sd2048 - rabs) <<< 1) : 23'(v6_val_reg);
        if (rv > 23'sd65535)
        begin
            fin_next = 17'h0FFFF;
        end
        else if (rv < -23'sd65536)
        begin
            fin_next = 17'h10000;
        end
        else
        begin
            fin_next = rv[16:0];
        end
    end

    assign en       = !skid_v_reg;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_lo_reg <= RANGE_LO_RST;
            range_hi_reg <= RANGE_HI_RST;
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            skid_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_RANGE_LO: range_lo_reg <= cfg_data;
                    REG_RANGE_HI: range_hi_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (en)
            begin
                v0_reg <= s_tvalid;
                v1_reg <= v0_reg && (kind0_reg == KIND_EVAL);
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
                v4_reg <= v3_reg;
                v5_reg <= v4_reg;
                v6_reg <= v5_reg;
                v7_reg <= v6_reg;
            end
            // output register with skid behind it
            if (!out_v_reg || m_tready)
            begin
                if (skid_v_reg)
                begin
                    out_v_reg  <= 1'b1;
                    skid_v_reg <= 1'b0;
                end
                else
                begin
                    out_v_reg <= v7_reg;
                end
            end
            else if (v7_reg && en)
            begin
                skid_v_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kind0_reg  <= s_tuser;
            tidx0_reg  <= s_tdata[9:0];
            tcode0_reg <= s_tdata[11:10];
            px0_reg    <= s_tdata[43:12];
            py0_reg    <= s_tdata[75:44];
            ridge0_reg <= s_tdata[76];

            fx1_reg <= fx;
            fy1_reg <= fy;
            r1_reg  <= ridge0_reg;

            tl2_reg <= dot(c_tl, dx0, dy0);
            tr2_reg <= dot(c_tr, dx1, dy0);
            bl2_reg <= dot(c_bl, dx0, dy1);
            br2_reg <= dot(c_br, dx1, dy1);
            r2_reg  <= r1_reg;

            tl3_reg <= tl2_reg;
            tr3_reg <= tr2_reg;
            bl3_reg <= bl2_reg;
            br3_reg <= br2_reg;
            r3_reg  <= r2_reg;

            top4_reg <= 19'(tl3_reg) + 19'(p_top >>> 16);
            bot4_reg <= 19'(bl3_reg) + 19'(p_bot >>> 16);
            sy4_reg  <= sy;
            r4_reg   <= r3_reg;

            n5_reg <= 19'(20'(top4_reg) + 20'(p_n >>> 16));
            r5_reg <= r4_reg;

            v6_val_reg <= v_next;
            r6_reg     <= r5_reg;

            fin_reg <= fin_next;
        end
        if (!out_v_reg || m_tready)
        begin
            out_d_reg <= skid_v_reg ? skid_d_reg : fin_reg;
        end
        else if (v7_reg && en)
        begin
            skid_d_reg <= fin_reg;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {7'd0, out_d_reg};

`include "gradient_noise_2d_unit_assert.svh"

    `GN2D_ASSERT_NOW(a_skid_behind_out, clk, rst_n, skid_v_reg, out_v_reg)
    `GN2D_ASSERT_NEXT(a_skid_fill, clk, rst_n, out_v_reg && !m_tready && v7_reg && !skid_v_reg, skid_v_reg)
    `GN2D_ASSERT_NEXT(a_write_no_result, clk, rst_n, en && v0_reg && (kind0_reg == KIND_WRITE), !v1_reg)

endmodule

`default_nettype wire

[rtl/gn2d_grad_ram.sv]
// ----------------------------------------------------------------------------
// gn2d_grad_ram
// Gradient code table copy: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module gn2d_grad_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [1:0]    wdata,
    input  wire logic          en,
    input  wire logic [AW-1:0] raddr,
    output logic [1:0]         rdata
);
    logic [1:0] mem [DEPTH];
    logic [1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

`default_nettype wire

[rtl/gn2d_fade.sv]
// ----------------------------------------------------------------------------
// gn2d_fade
// Three-stage quintic fade 6t^5-15t^4+10t^3 on a Q0.16 fraction.
// ----------------------------------------------------------------------------
`default_nettype none

module gn2d_fade (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [15:0] t,
    output logic [16:0]      s
);
    import gn2d_pkg::*;

    logic [15:0] t_reg;
    logic [31:0] t2_reg;
    logic [15:0] t3_reg;
    logic [20:0] poly_reg;
    logic [16:0] s_reg;

    logic [47:0] t3_prod;
    logic [36:0] poly_sum;
    logic [36:0] s_prod;
    logic [20:0] s_raw;
    logic [16:0] s_next;

    always_comb
    begin
        t3_prod  = 48'(t2_reg) * 48'(t_reg);
        poly_sum = (37'd10 << 32) + 37'(t2_reg) * 37'd6 - ((37'(t_reg) * 37'd15) << 16);
        s_prod   = 37'(t3_reg) * 37'(poly_reg);
        s_raw    = s_prod[36:16];
        s_next   = (s_raw > 21'(ONE_Q16)) ? ONE_Q16 : s_raw[16:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg    <= t;
            t2_reg   <= 32'(t) * 32'(t);
            t3_reg   <= t3_prod[47:32];
            poly_reg <= poly_sum[36:16];
            s_reg    <= s_next;
        end
    end

    assign s = s_reg;
endmodule

`default_nettype wire
